// File: sv/pfb_pkg.sv
// Package for the page-layout framebuffer pixel blend block.
// Holds shared constants, register and operation codes and the request struct.
// No dependencies.
package pfb_pkg;

  // Default store depth in bytes.
  localparam int unsigned STORE_BYTES_DEF = 1024;

  // Width of a byte address before it is cut down to the store depth.
  // Covers x + 255 * 31 and the read index.
  localparam int unsigned FULL_ADDR_W = 14;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COORD_W  = 9;
  localparam int unsigned WIDTH_W  = 8;
  localparam int unsigned HEIGHT_W = 7;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [WIDTH_W-1:0]  PANEL_WIDTH_RST  = 8'd128;
  localparam logic [HEIGHT_W-1:0] PANEL_HEIGHT_RST = 7'd64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 1'd1;

  // Operations.
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Blend modes.
  localparam logic [MODE_W-1:0] BLEND_COPY = 2'd0;
  localparam logic [MODE_W-1:0] BLEND_OR   = 2'd1;
  localparam logic [MODE_W-1:0] BLEND_AND  = 2'd2;
  localparam logic [MODE_W-1:0] BLEND_XOR  = 2'd3;

  localparam logic [BYTE_W-1:0] PIX_MASK_ONE = 8'h01;

  // One decoded request as it travels from decode into the blend stage.
  typedef struct packed {
    logic                   op;
    logic                   clip;
    logic                   oob;
    logic [FULL_ADDR_W-1:0] addr;
    logic [BYTE_W-1:0]      mask;
    logic                   on;
    logic [MODE_W-1:0]      mode;
  } pfb_req_t;

endpackage

// File: sv/pfb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/pfb_decode.sv
// Decode of one registered request: clipping, byte address and bit mask.
// Depends on pfb_pkg.
module pfb_decode #(
  parameter int unsigned STORE_BYTES = pfb_pkg::STORE_BYTES_DEF
) (
  input  logic                                op,
  input  logic signed [pfb_pkg::COORD_W-1:0]  x_coord,
  input  logic signed [pfb_pkg::COORD_W-1:0]  y_coord,
  input  logic                                pixel_lit,
  input  logic [pfb_pkg::MODE_W-1:0]          blend_mode,
  input  logic [pfb_pkg::INDEX_W-1:0]         byte_index,
  input  logic [pfb_pkg::WIDTH_W-1:0]         panel_width,
  input  logic [pfb_pkg::HEIGHT_W-1:0]        panel_height,
  output pfb_pkg::pfb_req_t                   req
);
  import pfb_pkg::*;

  localparam logic [FULL_ADDR_W-1:0] STORE_LIMIT = FULL_ADDR_W'(STORE_BYTES);

  logic                   coord_out;
  logic [FULL_ADDR_W-1:0] draw_addr;
  logic [FULL_ADDR_W-1:0] full_addr;
  logic                   addr_oob;

  always_comb begin
    // The sign bit catches negative coordinates; the low byte is compared
    // against the panel size.
    coord_out = x_coord[COORD_W-1] || y_coord[COORD_W-1] ||
                (x_coord[7:0] >= panel_width) ||
                (y_coord[7:0] >= {1'b0, panel_height});
    draw_addr = FULL_ADDR_W'(x_coord[7:0]) +
                FULL_ADDR_W'(panel_width) * FULL_ADDR_W'(y_coord[7:3]);
    full_addr = (op == OP_READ) ? FULL_ADDR_W'(byte_index) : draw_addr;
    addr_oob  = (full_addr >= STORE_LIMIT);

    req.op   = op;
    req.clip = (op == OP_DRAW) && (coord_out || addr_oob);
    req.oob  = addr_oob;
    req.addr = full_addr;
    req.mask = PIX_MASK_ONE << y_coord[2:0];
    req.on   = pixel_lit;
    req.mode = blend_mode;
  end

endmodule

// File: sv/pfb_blend.sv
// Blend stage: picks the current byte (store or last write), applies the
// blend mode and forms the result fields. Depends on pfb_pkg.
module pfb_blend (
  input  pfb_pkg::pfb_req_t             req,
  input  logic [pfb_pkg::BYTE_W-1:0]    ram_q,
  input  logic                          fwd_hit,
  input  logic [pfb_pkg::BYTE_W-1:0]    fwd_data,
  output logic [pfb_pkg::BYTE_W-1:0]    new_byte,
  output logic [pfb_pkg::BYTE_W-1:0]    read_byte,
  output logic                          clipped
);
  import pfb_pkg::*;

  logic [BYTE_W-1:0] cur;

  always_comb begin
    // The write of the item just ahead lands in the same edge as this
    // item's read, so its data is taken from the bypass.
    cur = fwd_hit ? fwd_data : ram_q;

    case (req.mode)
      BLEND_COPY: new_byte = req.on ? (cur | req.mask) : (cur & ~req.mask);
      BLEND_OR:   new_byte = req.on ? (cur | req.mask) : cur;
      BLEND_AND:  new_byte = req.on ? cur : (cur & ~req.mask);
      BLEND_XOR:  new_byte = req.on ? (cur ^ req.mask) : cur;
      default:    new_byte = cur;
    endcase

    read_byte = ((req.op == OP_READ) && !req.oob) ? cur : '0;
    clipped   = (req.op == OP_DRAW) && req.clip;
  end

endmodule

// File: sv/page_framebuffer_pixel_blend.sv
// Stages: input, blend and output registers, moved together. Throughput: one
// beat per cycle while the output is not stalled and no clearing pass runs;
// the single RAM write port and its registered read, bypassed for back-to-back
// writes to one byte, set this figure. Reset: synchronous, active low; then a
// clearing pass zeroes every byte, with in_ready low. Configuration is taken.
module page_framebuffer_pixel_blend #(
  parameter int unsigned STORE_BYTES = pfb_pkg::STORE_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_operation,
  input  logic signed [pfb_pkg::COORD_W-1:0]  in_x_coord,
  input  logic signed [pfb_pkg::COORD_W-1:0]  in_y_coord,
  input  logic                                in_pixel_lit,
  input  logic [pfb_pkg::MODE_W-1:0]          in_blend_mode,
  input  logic [pfb_pkg::INDEX_W-1:0]         in_byte_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pfb_pkg::BYTE_W-1:0]          out_read_byte,
  output logic                                out_clipped,
  input  logic                                cfg_we,
  input  logic [pfb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pfb_pkg::WIDTH_W-1:0]         cfg_data
);
  import pfb_pkg::*;

  localparam int unsigned ADDR_W = $clog2(STORE_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

  // Configuration.
  logic [WIDTH_W-1:0]  panel_width_r;
  logic [HEIGHT_W-1:0] panel_height_r;

  // Clearing pass.
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_idx_r;

  // Input stage.
  logic                       a_valid_r;
  logic                       a_op_r;
  logic signed [COORD_W-1:0]  a_x_r;
  logic signed [COORD_W-1:0]  a_y_r;
  logic                       a_on_r;
  logic [MODE_W-1:0]          a_mode_r;
  logic [INDEX_W-1:0]         a_index_r;

  // Blend stage.
  logic     b_valid_r;
  pfb_req_t b_req_r;
  pfb_req_t a_req;

  // Last write, for the bypass.
  logic              lw_valid_r;
  logic [ADDR_W-1:0] lw_addr_r;
  logic [BYTE_W-1:0] lw_data_r;

  // Output register.
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_read_byte_r;
  logic              out_clipped_r;

  logic              adv;
  logic              accept;
  logic              draw_we;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] b_addr;
  logic [BYTE_W-1:0] ram_q;
  logic              fwd_hit;
  logic [BYTE_W-1:0] new_byte;
  logic [BYTE_W-1:0] res_read_byte;
  logic              res_clipped;

  // The whole pipe moves together whenever the output register can load.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && !clearing_r;
  assign accept   = in_valid && in_ready;

  assign b_addr  = b_req_r.addr[ADDR_W-1:0];
  assign fwd_hit = lw_valid_r && (lw_addr_r == b_addr);
  assign draw_we = adv && b_valid_r && (b_req_r.op == OP_DRAW) && !b_req_r.clip;

  always_comb begin
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = '0;
    end else begin
      ram_we    = draw_we;
      ram_waddr = b_addr;
      ram_wdata = new_byte;
    end
  end

  pfb_decode #(
    .STORE_BYTES(STORE_BYTES)
  ) u_decode (
    .op          (a_op_r),
    .x_coord     (a_x_r),
    .y_coord     (a_y_r),
    .pixel_lit   (a_on_r),
    .blend_mode  (a_mode_r),
    .byte_index  (a_index_r),
    .panel_width (panel_width_r),
    .panel_height(panel_height_r),
    .req         (a_req)
  );

  pfb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_BYTES)
  ) u_frame_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (adv),
    .raddr(a_req.addr[ADDR_W-1:0]),
    .rdata(ram_q)
  );

  pfb_blend u_blend (
    .req      (b_req_r),
    .ram_q    (ram_q),
    .fwd_hit  (fwd_hit),
    .fwd_data (lw_data_r),
    .new_byte (new_byte),
    .read_byte(res_read_byte),
    .clipped  (res_clipped)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_width_r  <= PANEL_WIDTH_RST;
      panel_height_r <= PANEL_HEIGHT_RST;
      clearing_r     <= 1'b1;
      clr_idx_r      <= '0;
      a_valid_r      <= 1'b0;
      b_valid_r      <= 1'b0;
      lw_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PANEL_WIDTH:  panel_width_r  <= cfg_data;
          REG_PANEL_HEIGHT: panel_height_r <= cfg_data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (clearing_r) begin
        clr_idx_r <= clr_idx_r + ADDR_W'(1);
        if (clr_idx_r == LAST_ADDR) begin
          clearing_r <= 1'b0;
        end
      end
      if (adv) begin
        a_valid_r   <= accept;
        b_valid_r   <= a_valid_r;
        lw_valid_r  <= draw_we;
        out_valid_r <= b_valid_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_op_r    <= in_operation;
      a_x_r     <= in_x_coord;
      a_y_r     <= in_y_coord;
      a_on_r    <= in_pixel_lit;
      a_mode_r  <= in_blend_mode;
      a_index_r <= in_byte_index;
    end
    if (adv) begin
      b_req_r         <= a_req;
      lw_addr_r       <= b_addr;
      lw_data_r       <= new_byte;
      out_read_byte_r <= res_read_byte;
      out_clipped_r   <= res_clipped;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_byte = out_read_byte_r;
  assign out_clipped   = out_clipped_r;

endmodule

// File: sv/pfb_checker.sv
// Port-level checks for the page-layout framebuffer pixel blend block,
// bound to the top level. Depends on pfb_pkg.
module pfb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pfb_pkg::BYTE_W-1:0]    out_read_byte,
  input logic                          out_clipped
);

  // Reset starts the clearing pass, so no beat is taken right after it.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during the clearing pass");

  // A beat carries either a read byte or a clip flag, never both.
  a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_clipped && (out_read_byte != '0)))
    else $error("result has both a read byte and a clip flag");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_read_byte) && $stable(out_clipped))
    else $error("result payload changed while stalled");

endmodule

bind page_framebuffer_pixel_blend pfb_checker u_pfb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_read_byte(out_read_byte),
  .out_clipped  (out_clipped)
);
